// ===== rtl/core/i2cm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  // Operation codes carried by an input item
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Ending status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NACK_ADDR = 2'd1;
  localparam logic [1:0] ST_NACK_DATA = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_TWO_BYTE_REG = 2'd0;
  localparam logic [1:0] CFG_POLL_LIMIT   = 2'd1;
  localparam logic [1:0] CFG_TICKS_UNIT   = 2'd2;

  // Configuration reset values
  localparam logic       CFG_TWO_BYTE_RST = 1'b1;
  localparam logic [7:0] CFG_POLL_RST     = 8'd50;
  localparam logic [7:0] CFG_TICKS_RST    = 8'd1;

  // Wait lengths in delay units
  localparam logic [2:0] UNITS_1 = 3'd1;
  localparam logic [2:0] UNITS_2 = 3'd2;
  localparam logic [2:0] UNITS_4 = 3'd4;
  localparam logic [2:0] UNITS_5 = 3'd5;

  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'd0,
    PH_ST1   = 5'd1,
    PH_ST2   = 5'd2,
    PH_ST3   = 5'd3,
    PH_TXA   = 5'd4,
    PH_TXB   = 5'd5,
    PH_TXC   = 5'd6,
    PH_WA1   = 5'd7,
    PH_WA2   = 5'd8,
    PH_WA3   = 5'd9,
    PH_POLL  = 5'd10,
    PH_WEND  = 5'd11,
    PH_LOADW = 5'd12,
    PH_RD0   = 5'd13,
    PH_RBA   = 5'd14,
    PH_RBB   = 5'd15,
    PH_AK1   = 5'd16,
    PH_AK2   = 5'd17,
    PH_AK3   = 5'd18,
    PH_AK4   = 5'd19,
    PH_SP1   = 5'd20,
    PH_SP2   = 5'd21,
    PH_SP3   = 5'd22,
    PH_SP4   = 5'd23
  } phase_e;

  typedef enum logic [2:0] {
    STG_ADDR_W = 3'd0,
    STG_REG_HI = 3'd1,
    STG_REG_LO = 3'd2,
    STG_ADDR_R = 3'd3,
    STG_DATA   = 3'd4
  } stage_e;

  typedef struct packed {
    logic       two_byte_reg;
    logic [7:0] poll_limit;
    logic [7:0] ticks_unit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  device_address;
    logic [15:0] register_address;
    logic [7:0]  byte_count;
    logic [7:0]  write_byte;
    logic        sda_sample;
  } cmd_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       data_request;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic       start_fault;
  } res_t;

  typedef struct packed {
    phase_e      phase;
    logic [10:0] wait_cnt;
    logic [3:0]  bit_cnt;
    logic [7:0]  shift;
    logic [7:0]  bytes_left;
    logic [7:0]  poll_cnt;
    logic [6:0]  tgt_addr;
    logic [15:0] tgt_reg;
    logic        is_read;
    logic        fault;
    logic        scl;
    logic        sda_low;
    stage_e      stage;
    logic [1:0]  end_status;
  } st_t;

endpackage

`default_nettype wire

// ===== rtl/core/i2cm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Command and tick items into the master
interface i2cm_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [6:0]  device_address;
  logic [15:0] register_address;
  logic [7:0]  byte_count;
  logic [7:0]  write_byte;
  logic        sda_sample;

  modport source (
    output valid, operation, device_address, register_address, byte_count,
           write_byte, sda_sample,
    input  ready
  );
  modport sink (
    input  valid, operation, device_address, register_address, byte_count,
           write_byte, sda_sample,
    output ready
  );
endinterface

// Result items out of the master
interface i2cm_res_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_pull_low;
  logic [7:0] read_byte;
  logic       read_valid;
  logic       data_request;
  logic       busy_res;
  logic       done_res;
  logic [1:0] status;
  logic       start_fault;

  modport source (
    output valid, scl_level, sda_pull_low, read_byte, read_valid, data_request,
           busy_res, done_res, status, start_fault,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_pull_low, read_byte, read_valid, data_request,
           busy_res, done_res, status, start_fault,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/i2c_master_register_access.sv =====
`timescale 1ns / 1ps
`default_nettype none

// I2C master for device register writes and reads.
// Channels: cmd_i takes items (operation, addresses, byte count, write byte,
// sampled SDA); res_o returns exactly one result item per input item with
// the SCL and SDA drive levels, a received byte, a data request and the
// busy / done / status / start-fault flags. Configuration is a write port
// (cfg_we_i, cfg_idx_i, cfg_data_i); write it only while no transfer runs.
// An accepted item is held in an input register, then one step of the pin
// sequence runs and the result register loads, which puts its result on
// res_o. Throughput is one item per clock while res_o is taken; the
// sequencer state feeds back within that single step. A begin item starts a
// transfer while idle; every later item moves the pin sequence by one step,
// so line timing is set by the tick rate and ticks_per_delay_unit.
// Reset: the sequencer goes idle with both lines released, the configuration
// returns to two-byte register addresses, a poll limit of 50 and one tick per
// delay unit. Stall: when res_o is not taken, the result register holds, the
// input register still takes one item, then cmd_i.ready drops.
module i2c_master_register_access (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire [1:0]  cfg_idx_i,
  input  wire [7:0]  cfg_data_i,
  i2cm_cmd_if.sink   cmd_i,
  i2cm_res_if.source res_o
);
  import i2cm_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd_in;
  cmd_t cmd_q;
  logic in_vld_q;
  logic res_vld_q;
  res_t res_q;
  res_t res_d;
  st_t  st_q;
  st_t  st_d;
  logic advance;
  logic in_take;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{two_byte_reg: CFG_TWO_BYTE_RST,
                 poll_limit:   CFG_POLL_RST,
                 ticks_unit:   CFG_TICKS_RST};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_TWO_BYTE_REG: cfg_q.two_byte_reg <= cfg_data_i[0];
        CFG_POLL_LIMIT:   cfg_q.poll_limit   <= cfg_data_i;
        CFG_TICKS_UNIT:   cfg_q.ticks_unit   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cmd_in.operation        = cmd_i.operation;
  assign cmd_in.device_address   = cmd_i.device_address;
  assign cmd_in.register_address = cmd_i.register_address;
  assign cmd_in.byte_count       = cmd_i.byte_count;
  assign cmd_in.write_byte       = cmd_i.write_byte;
  assign cmd_in.sda_sample       = cmd_i.sda_sample;

  // Step when the result register is free or being taken
  assign advance     = in_vld_q && (!res_vld_q || res_o.ready);
  assign cmd_i.ready = !in_vld_q || advance;
  assign in_take     = cmd_i.valid && cmd_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q <= cmd_in;
    end
  end

  i2cm_step u_step (
    .st_i  (st_q),
    .cfg_i (cfg_q),
    .cmd_i (cmd_q),
    .st_o  (st_d),
    .res_o (res_d)
  );

  // Sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{phase:      PH_IDLE,
                wait_cnt:   '0,
                bit_cnt:    '0,
                shift:      '0,
                bytes_left: '0,
                poll_cnt:   '0,
                tgt_addr:   '0,
                tgt_reg:    '0,
                is_read:    1'b0,
                fault:      1'b0,
                scl:        1'b1,
                sda_low:    1'b0,
                stage:      STG_ADDR_W,
                end_status: ST_OK};
    end else if (advance) begin
      st_q <= st_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (advance) begin
      res_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid        = res_vld_q;
  assign res_o.scl_level    = res_q.scl_level;
  assign res_o.sda_pull_low = res_q.sda_pull_low;
  assign res_o.read_byte    = res_q.read_byte;
  assign res_o.read_valid   = res_q.read_valid;
  assign res_o.data_request = res_q.data_request;
  assign res_o.busy_res     = res_q.busy_res;
  assign res_o.done_res     = res_q.done_res;
  assign res_o.status       = res_q.status;
  assign res_o.start_fault  = res_q.start_fault;

endmodule

`default_nettype wire

// ===== rtl/core/i2cm_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One step of the pin sequence: next state and result for one item.
module i2cm_step (
  input  var i2cm_pkg::st_t  st_i,
  input  var i2cm_pkg::cfg_t cfg_i,
  input  var i2cm_pkg::cmd_t cmd_i,
  output i2cm_pkg::st_t      st_o,
  output i2cm_pkg::res_t     res_o
);
  import i2cm_pkg::*;

  logic [7:0] ticks_eff;
  st_t        nst;
  res_t       res;
  logic       do_start;
  logic       do_byte;
  logic [7:0] byte_val;
  logic       do_read;
  logic       do_stop;
  logic [1:0] stop_st;
  logic       do_next;
  logic       do_poll;
  logic [7:0] poll_base;
  logic [3:0] bit_inc;
  logic [7:0] shift_in;

  // Zero ticks per unit acts as one
  assign ticks_eff = (cfg_i.ticks_unit == 8'd0) ? 8'd1 : cfg_i.ticks_unit;
  assign bit_inc   = st_i.bit_cnt + 4'd1;
  assign shift_in  = {st_i.shift[6:0], cmd_i.sda_sample};

  function automatic logic [10:0] f_wait(input logic [2:0] units);
    return 11'(units) * 11'(ticks_eff);
  endfunction

  always_comb begin
    nst       = st_i;
    res       = '0;
    do_start  = 1'b0;
    do_byte   = 1'b0;
    byte_val  = '0;
    do_read   = 1'b0;
    do_stop   = 1'b0;
    stop_st   = ST_OK;
    do_next   = 1'b0;
    do_poll   = 1'b0;
    poll_base = st_i.poll_cnt;

    if (st_i.phase == PH_IDLE) begin
      // Latch a new transfer
      if (cmd_i.operation == OP_WRITE || cmd_i.operation == OP_READ) begin
        nst.tgt_addr   = cmd_i.device_address;
        nst.tgt_reg    = cmd_i.register_address;
        nst.bytes_left = cmd_i.byte_count;
        nst.is_read    = (cmd_i.operation == OP_READ);
        nst.fault      = 1'b0;
        nst.end_status = ST_OK;
        nst.stage      = STG_ADDR_W;
        do_start       = 1'b1;
      end
    end else if (st_i.phase == PH_POLL || st_i.phase == PH_LOADW ||
                 st_i.wait_cnt <= 11'd1) begin
      // End of the current phase
      case (st_i.phase)
        PH_ST1: begin
          if (!cmd_i.sda_sample) nst.fault = 1'b1;
          nst.sda_low  = 1'b1;
          nst.phase    = PH_ST2;
          nst.wait_cnt = f_wait(UNITS_4);
        end
        PH_ST2: begin
          if (cmd_i.sda_sample) nst.fault = 1'b1;
          nst.scl      = 1'b0;
          nst.phase    = PH_ST3;
          nst.wait_cnt = f_wait(UNITS_4);
        end
        PH_ST3: begin
          do_byte  = 1'b1;
          byte_val = {st_i.tgt_addr, st_i.stage == STG_ADDR_R};
        end
        PH_TXA: begin
          nst.sda_low  = ~st_i.shift[7];
          nst.phase    = PH_TXB;
          nst.wait_cnt = f_wait(UNITS_2);
        end
        PH_TXB: begin
          nst.scl      = 1'b1;
          nst.phase    = PH_TXC;
          nst.wait_cnt = f_wait(UNITS_2);
        end
        PH_TXC: begin
          nst.shift   = {st_i.shift[6:0], 1'b0};
          nst.bit_cnt = bit_inc;
          nst.scl     = 1'b0;
          if (bit_inc >= BITS_PER_BYTE) begin
            nst.phase    = PH_WA1;
            nst.wait_cnt = f_wait(UNITS_1);
          end else begin
            nst.phase    = PH_TXA;
            nst.wait_cnt = f_wait(UNITS_2);
          end
        end
        PH_WA1: begin
          nst.sda_low  = 1'b0;
          nst.phase    = PH_WA2;
          nst.wait_cnt = f_wait(UNITS_1);
        end
        PH_WA2: begin
          nst.scl      = 1'b1;
          nst.phase    = PH_WA3;
          nst.wait_cnt = f_wait(UNITS_1);
        end
        PH_WA3: begin
          nst.poll_cnt = '0;
          poll_base    = '0;
          do_poll      = 1'b1;
        end
        PH_POLL: begin
          do_poll = 1'b1;
        end
        PH_WEND: begin
          // Pick the next byte after an acknowledge
          case (st_i.stage)
            STG_ADDR_W: begin
              do_byte = 1'b1;
              if (cfg_i.two_byte_reg) begin
                nst.stage = STG_REG_HI;
                byte_val  = st_i.tgt_reg[15:8];
              end else begin
                nst.stage = STG_REG_LO;
                byte_val  = st_i.tgt_reg[7:0];
              end
            end
            STG_REG_HI: begin
              nst.stage = STG_REG_LO;
              do_byte   = 1'b1;
              byte_val  = st_i.tgt_reg[7:0];
            end
            STG_REG_LO: begin
              if (st_i.is_read) begin
                nst.stage = STG_ADDR_R;
                do_start  = 1'b1;
              end else begin
                do_next = 1'b1;
              end
            end
            STG_ADDR_R: begin
              if (st_i.bytes_left == 8'd0) begin
                do_stop = 1'b1;
              end else begin
                do_read = 1'b1;
              end
            end
            default: begin
              do_next = 1'b1;
            end
          endcase
        end
        PH_LOADW: begin
          nst.stage      = STG_DATA;
          nst.bytes_left = st_i.bytes_left - 8'd1;
          do_byte        = 1'b1;
          byte_val       = cmd_i.write_byte;
        end
        PH_RD0: begin
          nst.phase    = PH_RBA;
          nst.wait_cnt = f_wait(UNITS_2);
        end
        PH_RBA: begin
          nst.scl      = 1'b1;
          nst.phase    = PH_RBB;
          nst.wait_cnt = f_wait(UNITS_2);
        end
        PH_RBB: begin
          nst.shift   = shift_in;
          nst.bit_cnt = bit_inc;
          nst.scl     = 1'b0;
          if (bit_inc >= BITS_PER_BYTE) begin
            res.read_valid = 1'b1;
            res.read_byte  = shift_in;
            nst.bytes_left = st_i.bytes_left - 8'd1;
            nst.phase      = PH_AK1;
          end else begin
            nst.phase = PH_RBA;
          end
          nst.wait_cnt = f_wait(UNITS_2);
        end
        PH_AK1: begin
          nst.sda_low  = (st_i.bytes_left != 8'd0);
          nst.phase    = PH_AK2;
          nst.wait_cnt = f_wait(UNITS_2);
        end
        PH_AK2: begin
          nst.scl      = 1'b1;
          nst.phase    = PH_AK3;
          nst.wait_cnt = f_wait(UNITS_2);
        end
        PH_AK3: begin
          nst.scl      = 1'b0;
          nst.phase    = PH_AK4;
          nst.wait_cnt = f_wait(UNITS_2);
        end
        PH_AK4: begin
          if (st_i.bytes_left == 8'd0) begin
            do_stop = 1'b1;
          end else begin
            do_read = 1'b1;
          end
        end
        PH_SP1: begin
          nst.sda_low  = 1'b1;
          nst.phase    = PH_SP2;
          nst.wait_cnt = f_wait(UNITS_4);
        end
        PH_SP2: begin
          nst.scl      = 1'b1;
          nst.phase    = PH_SP3;
          nst.wait_cnt = f_wait(UNITS_4);
        end
        PH_SP3: begin
          nst.sda_low  = 1'b0;
          nst.phase    = PH_SP4;
          nst.wait_cnt = f_wait(UNITS_4);
        end
        PH_SP4: begin
          res.done_res = 1'b1;
          nst.phase    = PH_IDLE;
          nst.wait_cnt = '0;
        end
        default: begin
          nst.phase   = PH_IDLE;
          nst.scl     = 1'b1;
          nst.sda_low = 1'b0;
        end
      endcase
    end else begin
      // Count down the wait
      nst.wait_cnt = st_i.wait_cnt - 11'd1;
    end

    // Acknowledge poll: one per item
    if (do_poll) begin
      if (!cmd_i.sda_sample) begin
        nst.scl      = 1'b0;
        nst.phase    = PH_WEND;
        nst.wait_cnt = f_wait(UNITS_1);
      end else if (poll_base >= cfg_i.poll_limit) begin
        do_stop = 1'b1;
        stop_st = (st_i.stage inside {STG_ADDR_W, STG_ADDR_R}) ? ST_NACK_ADDR
                                                               : ST_NACK_DATA;
      end else begin
        nst.poll_cnt = poll_base + 8'd1;
        nst.phase    = PH_POLL;
      end
    end

    // Request the next write byte or finish
    if (do_next) begin
      if (st_i.bytes_left == 8'd0) begin
        do_stop = 1'b1;
      end else begin
        res.data_request = 1'b1;
        nst.phase        = PH_LOADW;
      end
    end

    if (do_start) begin
      nst.scl      = 1'b1;
      nst.sda_low  = 1'b0;
      nst.phase    = PH_ST1;
      nst.wait_cnt = f_wait(UNITS_5);
    end
    if (do_byte) begin
      nst.shift    = byte_val;
      nst.bit_cnt  = '0;
      nst.scl      = 1'b0;
      nst.phase    = PH_TXA;
      nst.wait_cnt = f_wait(UNITS_2);
    end
    if (do_read) begin
      nst.sda_low  = 1'b0;
      nst.shift    = '0;
      nst.bit_cnt  = '0;
      nst.phase    = PH_RD0;
      nst.wait_cnt = f_wait(UNITS_2);
    end
    if (do_stop) begin
      nst.end_status = stop_st;
      nst.scl        = 1'b0;
      nst.phase      = PH_SP1;
      nst.wait_cnt   = f_wait(UNITS_4);
    end

    // Pins and flags after this item
    res.scl_level    = nst.scl;
    res.sda_pull_low = nst.sda_low;
    res.busy_res     = (nst.phase != PH_IDLE);
    res.status       = res.done_res ? nst.end_status : ST_OK;
    res.start_fault  = nst.fault;
  end

  assign st_o  = nst;
  assign res_o = res;

endmodule

`default_nettype wire

// ===== tb/i2cm_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the I2C register master, predicts one result per
// accepted input item and compares the results in order.
module i2cm_checker
  import i2cm_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        cfg_we_i,
  input  wire [1:0]  cfg_idx_i,
  input  wire [7:0]  cfg_data_i,
  i2cm_cmd_if        cmd_i,
  i2cm_res_if        res_i,
  output int         fail_count_o,
  output int         pending_o
);

  // Shadow copy of the configuration registers
  logic        two_byte_reg;
  logic [7:0]  poll_limit;
  logic [7:0]  ticks_unit;

  // Sequencer state
  phase_e      phase;
  logic [10:0] wait_cnt;
  logic [3:0]  bit_cnt;
  logic [7:0]  shifter;
  logic [7:0]  bytes_left;
  logic [7:0]  poll_cnt;
  logic [6:0]  tgt_addr;
  logic [15:0] tgt_reg;
  logic        reading;
  logic        fault;
  logic        scl;
  logic        sda_low;
  stage_e      stage;
  logic [1:0]  end_status;

  // Strobes of the item being predicted
  logic        req;
  logic        got_byte;
  logic [7:0]  rx_byte;
  logic        finished;

  res_t        expected_q[$];
  int          failures = 0;
  int          result_no = 0;

  function void clear_model();
    two_byte_reg = CFG_TWO_BYTE_RST;
    poll_limit   = CFG_POLL_RST;
    ticks_unit   = CFG_TICKS_RST;
    phase        = PH_IDLE;
    wait_cnt     = '0;
    bit_cnt      = '0;
    shifter      = '0;
    bytes_left   = '0;
    poll_cnt     = '0;
    tgt_addr     = '0;
    tgt_reg      = '0;
    reading      = 1'b0;
    fault        = 1'b0;
    scl          = 1'b1;
    sda_low      = 1'b0;
    stage        = STG_ADDR_W;
    end_status   = ST_OK;
  endfunction

  // Enter a phase that lasts a number of delay units
  function void arm_wait(phase_e next, logic [2:0] units);
    logic [10:0] per_unit;
    per_unit = (ticks_unit == 8'd0) ? 11'd1 : {3'd0, ticks_unit};
    phase    = next;
    wait_cnt = per_unit * units;
  endfunction

  function void start_cond();
    scl     = 1'b1;
    sda_low = 1'b0;
    arm_wait(PH_ST1, UNITS_5);
  endfunction

  function void send_byte(logic [7:0] value);
    shifter = value;
    bit_cnt = '0;
    scl     = 1'b0;
    arm_wait(PH_TXA, UNITS_2);
  endfunction

  function void recv_byte();
    sda_low = 1'b0;
    shifter = '0;
    bit_cnt = '0;
    arm_wait(PH_RD0, UNITS_2);
  endfunction

  function void stop_cond(logic [1:0] st);
    end_status = st;
    scl        = 1'b0;
    arm_wait(PH_SP1, UNITS_4);
  endfunction

  // Request the next write byte, or stop when none is left
  function void next_data();
    if (bytes_left == 8'd0) begin
      stop_cond(ST_OK);
    end else begin
      req   = 1'b1;
      phase = PH_LOADW;
    end
  endfunction

  // Pick the next byte stage once a sent byte was acknowledged
  function void after_ack();
    case (stage)
      STG_ADDR_W: begin
        if (two_byte_reg) begin
          stage = STG_REG_HI;
          send_byte(tgt_reg[15:8]);
        end else begin
          stage = STG_REG_LO;
          send_byte(tgt_reg[7:0]);
        end
      end
      STG_REG_HI: begin
        stage = STG_REG_LO;
        send_byte(tgt_reg[7:0]);
      end
      STG_REG_LO: begin
        if (reading) begin
          stage = STG_ADDR_R;
          start_cond();
        end else begin
          next_data();
        end
      end
      STG_ADDR_R: begin
        if (bytes_left == 8'd0) begin
          stop_cond(ST_OK);
        end else begin
          recv_byte();
        end
      end
      default: next_data();
    endcase
  endfunction

  // One acknowledge poll: low means ACK, high counts up to the limit
  function void poll_ack(logic s);
    if (!s) begin
      scl = 1'b0;
      arm_wait(PH_WEND, UNITS_1);
    end else if (poll_cnt >= poll_limit) begin
      stop_cond((stage == STG_ADDR_W || stage == STG_ADDR_R) ? ST_NACK_ADDR : ST_NACK_DATA);
    end else begin
      poll_cnt = poll_cnt + 8'd1;
      phase    = PH_POLL;
    end
  endfunction

  // Leave the current phase
  function void end_phase(logic s, logic [7:0] wbyte);
    case (phase)
      PH_ST1: begin
        if (!s) fault = 1'b1;
        sda_low = 1'b1;
        arm_wait(PH_ST2, UNITS_4);
      end
      PH_ST2: begin
        if (s) fault = 1'b1;
        scl = 1'b0;
        arm_wait(PH_ST3, UNITS_4);
      end
      PH_ST3: send_byte({tgt_addr, stage == STG_ADDR_R});
      PH_TXA: begin
        sda_low = ~shifter[7];
        arm_wait(PH_TXB, UNITS_2);
      end
      PH_TXB: begin
        scl = 1'b1;
        arm_wait(PH_TXC, UNITS_2);
      end
      PH_TXC: begin
        shifter = {shifter[6:0], 1'b0};
        bit_cnt = bit_cnt + 4'd1;
        scl     = 1'b0;
        if (bit_cnt >= BITS_PER_BYTE) arm_wait(PH_WA1, UNITS_1);
        else arm_wait(PH_TXA, UNITS_2);
      end
      PH_WA1: begin
        sda_low = 1'b0;
        arm_wait(PH_WA2, UNITS_1);
      end
      PH_WA2: begin
        scl = 1'b1;
        arm_wait(PH_WA3, UNITS_1);
      end
      PH_WA3: begin
        poll_cnt = '0;
        poll_ack(s);
      end
      PH_POLL: poll_ack(s);
      PH_WEND: after_ack();
      PH_LOADW: begin
        stage      = STG_DATA;
        bytes_left = bytes_left - 8'd1;
        send_byte(wbyte);
      end
      PH_RD0: arm_wait(PH_RBA, UNITS_2);
      PH_RBA: begin
        scl = 1'b1;
        arm_wait(PH_RBB, UNITS_2);
      end
      PH_RBB: begin
        shifter = {shifter[6:0], s};
        bit_cnt = bit_cnt + 4'd1;
        scl     = 1'b0;
        if (bit_cnt >= BITS_PER_BYTE) begin
          got_byte   = 1'b1;
          rx_byte    = shifter;
          bytes_left = bytes_left - 8'd1;
          arm_wait(PH_AK1, UNITS_2);
        end else begin
          arm_wait(PH_RBA, UNITS_2);
        end
      end
      PH_AK1: begin
        sda_low = (bytes_left != 8'd0);
        arm_wait(PH_AK2, UNITS_2);
      end
      PH_AK2: begin
        scl = 1'b1;
        arm_wait(PH_AK3, UNITS_2);
      end
      PH_AK3: begin
        scl = 1'b0;
        arm_wait(PH_AK4, UNITS_2);
      end
      PH_AK4: begin
        if (bytes_left == 8'd0) stop_cond(ST_OK);
        else recv_byte();
      end
      PH_SP1: begin
        sda_low = 1'b1;
        arm_wait(PH_SP2, UNITS_4);
      end
      PH_SP2: begin
        scl = 1'b1;
        arm_wait(PH_SP3, UNITS_4);
      end
      PH_SP3: begin
        sda_low = 1'b0;
        arm_wait(PH_SP4, UNITS_4);
      end
      PH_SP4: begin
        finished = 1'b1;
        phase    = PH_IDLE;
        wait_cnt = '0;
      end
      default: begin
        phase   = PH_IDLE;
        scl     = 1'b1;
        sda_low = 1'b0;
      end
    endcase
  endfunction

  // Advance the sequencer by one item and build its result
  function res_t predict_item(cmd_t item);
    res_t r;
    req      = 1'b0;
    got_byte = 1'b0;
    rx_byte  = '0;
    finished = 1'b0;
    if (phase == PH_IDLE) begin
      if (item.operation == OP_WRITE || item.operation == OP_READ) begin
        tgt_addr   = item.device_address;
        tgt_reg    = item.register_address;
        bytes_left = item.byte_count;
        reading    = (item.operation == OP_READ);
        fault      = 1'b0;
        end_status = ST_OK;
        stage      = STG_ADDR_W;
        start_cond();
      end
    end else if (phase == PH_POLL || phase == PH_LOADW || wait_cnt <= 11'd1) begin
      end_phase(item.sda_sample, item.write_byte);
    end else begin
      wait_cnt = wait_cnt - 11'd1;
    end
    r.scl_level    = scl;
    r.sda_pull_low = sda_low;
    r.read_byte    = rx_byte;
    r.read_valid   = got_byte;
    r.data_request = req;
    r.busy_res     = (phase != PH_IDLE);
    r.done_res     = finished;
    r.status       = finished ? end_status : ST_OK;
    r.start_fault  = fault;
    return r;
  endfunction

  function void report(string msg);
    failures++;
    if (failures <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      report($sformatf("result %0d %s expected %0h got %0h", result_no, name, want, got));
    end
  endfunction

  // Match a result against the oldest expectation
  function void check_result(res_t got);
    res_t want;
    result_no++;
    if (expected_q.size() == 0) begin
      report($sformatf("result %0d arrived with nothing expected", result_no));
      return;
    end
    want = expected_q.pop_front();
    compare_field("scl_level", 8'(want.scl_level), 8'(got.scl_level));
    compare_field("sda_pull_low", 8'(want.sda_pull_low), 8'(got.sda_pull_low));
    compare_field("read_byte", want.read_byte, got.read_byte);
    compare_field("read_valid", 8'(want.read_valid), 8'(got.read_valid));
    compare_field("data_request", 8'(want.data_request), 8'(got.data_request));
    compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
    compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
    compare_field("status", 8'(want.status), 8'(got.status));
    compare_field("start_fault", 8'(want.start_fault), 8'(got.start_fault));
  endfunction

  // Retire results before predicting the item taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    res_t seen;
    cmd_t item;
    if (!rst_ni) begin
      clear_model();
      expected_q.delete();
    end else begin
      if (res_i.valid === 1'b1 && res_i.ready === 1'b1) begin
        seen.scl_level    = res_i.scl_level;
        seen.sda_pull_low = res_i.sda_pull_low;
        seen.read_byte    = res_i.read_byte;
        seen.read_valid   = res_i.read_valid;
        seen.data_request = res_i.data_request;
        seen.busy_res     = res_i.busy_res;
        seen.done_res     = res_i.done_res;
        seen.status       = res_i.status;
        seen.start_fault  = res_i.start_fault;
        check_result(seen);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TWO_BYTE_REG: two_byte_reg = cfg_data_i[0];
          CFG_POLL_LIMIT:   poll_limit = cfg_data_i;
          CFG_TICKS_UNIT:   ticks_unit = cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.valid === 1'b1 && cmd_i.ready === 1'b1) begin
        item.operation        = cmd_i.operation;
        item.device_address   = cmd_i.device_address;
        item.register_address = cmd_i.register_address;
        item.byte_count       = cmd_i.byte_count;
        item.write_byte       = cmd_i.write_byte;
        item.sda_sample       = cmd_i.sda_sample;
        expected_q.push_back(predict_item(item));
      end
    end
    pending_o    = expected_q.size();
    fail_count_o = failures;
  end

endmodule

// ===== tb/i2c_master_register_access_test.sv =====
`timescale 1ns / 1ps

module i2c_master_register_access_test;
  import i2cm_pkg::*;

  localparam logic [1:0]  OP_SPARE        = 2'd3;
  localparam int unsigned CYCLE_LIMIT     = 20_000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned STRAY_WINDOW    = 10;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = CFG_TWO_BYTE_REG;
  logic [7:0]  cfg_data = '0;
  int          fail_count;
  int          pending;
  int unsigned done_count = 0;
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  bit          hold_off_req = 1'b0;

  i2cm_cmd_if cmd_if();
  i2cm_res_if res_if();

  i2c_master_register_access u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .cmd_i      (cmd_if),
    .res_o      (res_if)
  );

  i2cm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .cmd_i        (cmd_if),
    .res_i        (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Count finished transfers and bound the run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (res_if.valid === 1'b1 && res_if.ready === 1'b1 && res_if.done_res === 1'b1) begin
      done_count <= done_count + 1;
    end
    if (cycle_count == CYCLE_LIMIT) begin
      $display("i2c_master_register_access_test failed");
      $finish;
    end
  end

  // Take results on a stall pattern, with steady stretches and one long hold-off
  initial begin : result_taker
    logic [15:0] pat;
    int unsigned seg;
    bit          steady;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_off_req) begin
        @(negedge clk_i);
        res_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        pat    = 16'($urandom);
        seg    = $urandom_range(8, 64);
        steady = ($urandom_range(0, 3) == 0);
        repeat (seg) begin
          @(negedge clk_i);
          res_if.ready <= steady ? 1'b1 : ~(pat[0] & pat[1]);
          pat = {pat[0], pat[15:1]};
        end
      end
    end
  end

  function automatic cmd_t random_item(int unsigned one_pct);
    cmd_t c;
    c.operation        = OP_TICK;
    c.device_address   = 7'($urandom);
    c.register_address = 16'($urandom);
    c.byte_count       = 8'($urandom);
    c.write_byte       = 8'($urandom);
    c.sda_sample       = ($urandom_range(0, 99) < one_pct);
    return c;
  endfunction

  // Offer one item in bursts with random gaps; return at the next falling edge
  task automatic offer(input cmd_t c);
    if (burst_left == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
    end
    cmd_if.valid            <= 1'b1;
    cmd_if.operation        <= c.operation;
    cmd_if.device_address   <= c.device_address;
    cmd_if.register_address <= c.register_address;
    cmd_if.byte_count       <= c.byte_count;
    cmd_if.write_byte       <= c.write_byte;
    cmd_if.sda_sample       <= c.sda_sample;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every expected result has come
  task automatic drain();
    cmd_if.valid <= 1'b0;
    @(negedge clk_i);
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  // Feed ticks until the transfer count reaches the goal; early begins are ignored by a busy block
  task automatic tick_until_done(int unsigned goal, int unsigned one_pct, int unsigned stray);
    cmd_t        item;
    int unsigned n;
    n = 0;
    while (done_count < goal) begin
      item = random_item(one_pct);
      case ($urandom_range(0, 19))
        0:       item.operation = OP_SPARE;
        1:       item.operation = (n < stray) ? OP_WRITE : OP_TICK;
        2:       item.operation = (n < stray) ? OP_READ : OP_TICK;
        default: item.operation = OP_TICK;
      endcase
      offer(item);
      n++;
    end
  endtask

  // Run whole transfers with random content and byte counts of zero to three
  task automatic run_transfers(int unsigned count, int unsigned one_pct, bit read_first);
    cmd_t        item;
    int unsigned goal;
    for (int unsigned t = 0; t < count; t++) begin
      item = random_item(one_pct);
      item.operation  = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
      item.byte_count = 8'($urandom_range(0, 3));
      if (read_first && t == 0) begin
        item.operation  = OP_READ;
        item.byte_count = 8'd2;
      end
      goal = done_count + 1;
      offer(item);
      tick_until_done(goal, one_pct, STRAY_WINDOW);
    end
  endtask

  // Reprogram all registers while idle, then run a batch of transfers
  task automatic run_phase(logic two_byte, logic [7:0] limit, logic [7:0] ticks,
                           int unsigned one_pct, int unsigned count, bit read_first);
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_TWO_BYTE_REG;
    cfg_data <= {7'd0, two_byte};
    @(negedge clk_i);
    cfg_idx  <= CFG_POLL_LIMIT;
    cfg_data <= limit;
    @(negedge clk_i);
    cfg_idx  <= CFG_TICKS_UNIT;
    cfg_data <= ticks;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    @(negedge clk_i);
    run_transfers(count, one_pct, read_first);
  endtask

  initial begin : stimulus
    cmd_t item;
    cmd_if.valid            = 1'b0;
    cmd_if.operation        = OP_TICK;
    cmd_if.device_address   = '0;
    cmd_if.register_address = '0;
    cmd_if.byte_count       = '0;
    cmd_if.write_byte       = '0;
    cmd_if.sda_sample       = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Tick and unused operation while idle, all fields low then high
    item = '0;
    offer(item);
    item = '1;
    item.operation = OP_SPARE;
    offer(item);
    // Write one byte to the top device and register address
    item = '1;
    item.operation  = OP_WRITE;
    item.byte_count = 8'd1;
    offer(item);
    // Begins and unused operation while busy
    item = '0;
    item.operation = OP_READ;
    offer(item);
    item = '1;
    item.operation = OP_WRITE;
    offer(item);
    item = '1;
    item.operation = OP_SPARE;
    offer(item);
    for (int k = 0; k < 16; k++) begin
      item = (k % 2 == 0) ? '0 : '1;
      item.operation = OP_TICK;
      offer(item);
    end

    // Finish the write behind a long receiver hold-off
    hold_off_req = 1'b1;
    tick_until_done(1, 20, 0);

    // One-byte register address, zero ticks per unit, a two-byte read
    run_phase(1'b0, 8'd3, 8'd0, 35, 1, 1'b1);
    // Doubled delay unit and an address left unacknowledged
    run_phase(1'b1, 8'd0, 8'd2, 100, 1, 1'b0);

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("i2c_master_register_access_test passed");
    end else begin
      $display("i2c_master_register_access_test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_if.sv
rtl/core/i2cm_step.sv
rtl/core/i2c_master_register_access.sv
tb/i2cm_checker.sv
tb/i2c_master_register_access_test.sv
